@@ hw/rtl/htfd_pkg.sv @@
// ----------------------------------------------------------------------------
// htfd_pkg
// shared constants for the humidity/temperature frame decoder and its checker
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int unsigned KeptBytes     = 5;
  localparam int unsigned MinFrameBytes = 5;
  localparam int unsigned MaxFrameBytes = 8;
  localparam int unsigned HumidityLimit = 1000;

  localparam logic [1:0] RegSensorType = 2'd0;
  localparam logic [1:0] RegFrameBytes = 2'd1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusChecksum = 2'd1;
  localparam logic [1:0] StatusRange    = 2'd2;

  localparam logic [1:0] SensorOneByte = 2'd0;

endpackage

@@ hw/rtl/humidity_temp_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Takes sensor frame bytes one word at a time and decodes each complete frame
// into humidity, temperature and a status.
//
// Input channel: data_byte_i with in_valid_i / in_stall_o. Output channel:
// humidity_tenths_o, temperature_tenths_o, status_o with out_valid_o /
// out_stall_i. A word moves when valid is high and stall is low.
// Bytes 0 to 4 of a frame are kept; later bytes up to the frame length are
// counted and dropped. The last byte of a frame yields one result word,
// which passes through the frame register and pending flag and then the
// result register. Other bytes yield nothing. Throughput is one byte per
// cycle while in_stall_o is low, set by the single decode stage between the
// frame register and the result register. When the receiver stalls, the
// result is held; a finished frame waits in the frame register, and only
// then does in_stall_o rise. Reset clears the byte position, the pending
// flag and the result valid, and sets sensor type 0 and frame length 5.
// Configuration writes go through the cfg_we_i / cfg_index_i / cfg_data_i
// port; the user must write only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [3:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        humidity_tenths_o,
  output logic signed [15:0] temperature_tenths_o,
  output logic [1:0]         status_o
);

  logic [1:0]  sensor_type_q;
  logic [3:0]  frame_bytes_q;
  logic [3:0]  pos_q, pos_d;
  logic        pend_q, pend_d;
  logic [7:0]  frame_q [htfd_pkg::KeptBytes];
  logic        out_valid_q, out_valid_d;
  logic [15:0] hum_q, hum_d;
  logic [15:0] temp_q, temp_d;
  logic [1:0]  status_q, status_d;

  logic        in_accept;
  logic        advance;
  logic [3:0]  eff_len;
  logic        last_byte;
  logic [7:0]  sum;
  logic [15:0] hum_raw;
  logic [15:0] temp_raw;
  logic [14:0] mag;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = pend_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    if (frame_bytes_q < 4'(htfd_pkg::MinFrameBytes)) begin
      eff_len = 4'(htfd_pkg::MinFrameBytes);
    end else if (frame_bytes_q > 4'(htfd_pkg::MaxFrameBytes)) begin
      eff_len = 4'(htfd_pkg::MaxFrameBytes);
    end else begin
      eff_len = frame_bytes_q;
    end
  end

  assign last_byte = (5'(pos_q) + 5'd1) >= 5'(eff_len);

  always_comb begin
    pos_d  = pos_q;
    pend_d = pend_q;
    if (advance) begin
      pend_d = 1'b0;
    end
    if (in_accept) begin
      if (last_byte) begin
        pos_d  = '0;
        pend_d = 1'b1;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  // decode from the stored frame
  assign sum = frame_q[0] + frame_q[1] + frame_q[2] + frame_q[3];
  assign mag = {frame_q[2][6:0], frame_q[3]};

  always_comb begin
    if (sensor_type_q == htfd_pkg::SensorOneByte) begin
      hum_raw  = 16'(frame_q[0]) * 16'd10;
      temp_raw = 16'(frame_q[2]) * 16'd10 + 16'(frame_q[3][3:0]);
    end else begin
      hum_raw  = {frame_q[0], frame_q[1]};
      temp_raw = frame_q[2][7] ? (16'd0 - 16'(mag)) : 16'(mag);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    hum_d       = hum_q;
    temp_d      = temp_q;
    status_d    = status_q;
    if (advance) begin
      out_valid_d = pend_q;
      if (sum != frame_q[4]) begin
        hum_d    = '0;
        temp_d   = '0;
        status_d = htfd_pkg::StatusChecksum;
      end else begin
        hum_d    = hum_raw;
        temp_d   = temp_raw;
        status_d = (hum_raw > 16'(htfd_pkg::HumidityLimit)) ? htfd_pkg::StatusRange
                                                             : htfd_pkg::StatusOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_type_q <= htfd_pkg::SensorOneByte;
      frame_bytes_q <= 4'(htfd_pkg::MinFrameBytes);
      pos_q         <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          htfd_pkg::RegSensorType: sensor_type_q <= cfg_data_i[1:0];
          htfd_pkg::RegFrameBytes: frame_bytes_q <= cfg_data_i;
          default: ;
        endcase
      end
      pos_q       <= pos_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // frame bytes and result payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < htfd_pkg::KeptBytes; i++) begin
      if (in_accept && pos_q == 4'(i)) begin
        frame_q[i] <= data_byte_i;
      end
    end
    hum_q    <= hum_d;
    temp_q   <= temp_d;
    status_q <= status_d;
  end

  assign out_valid_o          = out_valid_q;
  assign humidity_tenths_o    = hum_q;
  assign temperature_tenths_o = signed'(temp_q);
  assign status_o             = status_q;

endmodule

@@ hw/rtl/htfd_checker.sv @@
// ----------------------------------------------------------------------------
// htfd_checker
// port-level checks for the humidity/temperature frame decoder
// ----------------------------------------------------------------------------
module htfd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [15:0]        humidity_tenths_o,
  input logic signed [15:0] temperature_tenths_o,
  input logic [1:0]         status_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(humidity_tenths_o)
      && $stable(temperature_tenths_o) && $stable(status_o)))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a byte taken two cycles before");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == htfd_pkg::StatusChecksum)
      |-> (humidity_tenths_o == 16'd0 && temperature_tenths_o == 16'sd0))
    else $error("checksum error with nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == htfd_pkg::StatusOk
      || status_o == htfd_pkg::StatusChecksum || status_o == htfd_pkg::StatusRange))
    else $error("undefined status code");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .humidity_tenths_o    (humidity_tenths_o),
  .temperature_tenths_o (temperature_tenths_o),
  .status_o             (status_o)
);
